/* hdl/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Implication helpers used by the concurrent checks in the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |-> (rhs)) \
    else $error("assertion failed");
// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (lhs) |=> (rhs)) \
    else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, lhs, rhs)
`define ASSERT_NEXT(label, clk, rst_n, lhs, rhs)
`endif
`endif

/* hdl/vht_pkg.sv */
// ----------------------------------------------------------------------------
// Visibility hysteresis table package
// Item types, table entry layout, operation codes and register indexes.
// ----------------------------------------------------------------------------
package vht_pkg;

  // Number of slots the 8-bit slot field can address.
  localparam int unsigned SLOT_SPAN = 256;

  // Register indexes of the configuration port.
  localparam logic REG_SHOW_THRESHOLD = 1'b0;
  localparam logic REG_HIDE_THRESHOLD = 1'b1;

  // Operation codes of an input item.
  typedef enum logic [1:0] {
    OP_OBSERVE  = 2'd0,
    OP_UNTESTED = 2'd1,
    OP_EVICT    = 2'd2
  } op_e;

  typedef struct packed {
    logic [1:0] operation;
    logic [7:0] slot;
    logic       seen_visible;
  } in_item_t;

  typedef struct packed {
    logic       draw_object;
    logic [7:0] slot_echo;
  } out_item_t;

  // Stored part of one table entry; the valid bit lives in flops.
  typedef struct packed {
    logic       hidden;
    logic [7:0] visible_run;
    logic [7:0] hidden_run;
  } entry_t;

  // Table write request from the update logic.
  typedef struct packed {
    logic       en;
    logic       valid;
    logic [7:0] slot;
    entry_t     data;
  } tbl_wr_t;

  typedef struct packed {
    logic [7:0] show_threshold;
    logic [7:0] hide_threshold;
  } cfg_t;

endpackage

/* hdl/vht_cfg.sv */
// ----------------------------------------------------------------------------
// Configuration registers
// APB-style access to the show and hide thresholds.
// ----------------------------------------------------------------------------
module vht_cfg (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready,
  output vht_pkg::cfg_t cfg_o
);

  vht_pkg::cfg_t cfg_q, cfg_d;
  logic          wr_en;
  logic          reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite && pready;

  // Register write decode.
  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      if (reg_sel == vht_pkg::REG_SHOW_THRESHOLD) begin
        cfg_d.show_threshold = pwdata[7:0];
      end else begin
        cfg_d.hide_threshold = pwdata[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.show_threshold <= 8'd2;
      cfg_q.hide_threshold <= 8'd3;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Read data mux.
  always_comb begin
    if (reg_sel == vht_pkg::REG_SHOW_THRESHOLD) begin
      prdata = {24'd0, cfg_q.show_threshold};
    end else begin
      prdata = {24'd0, cfg_q.hide_threshold};
    end
  end

  assign cfg_o = cfg_q;

endmodule

/* hdl/vht_table.sv */
// ----------------------------------------------------------------------------
// Entry table
// Entry memory with a registered read and write bypass, plus valid flops.
// ----------------------------------------------------------------------------
module vht_table #(
  parameter int unsigned ENTRIES = 256
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rd_en_i,
  input  logic [7:0]       rd_slot_i,
  output vht_pkg::entry_t  rd_data_o,
  input  logic [7:0]       lk_slot_i,
  output logic             lk_valid_o,
  input  vht_pkg::tbl_wr_t wr_i
);

  localparam int unsigned Depth = (ENTRIES < vht_pkg::SLOT_SPAN) ? ENTRIES
                                                                  : vht_pkg::SLOT_SPAN;
  localparam int unsigned IdxW  = $clog2(Depth);

  vht_pkg::entry_t mem_q [Depth];
  vht_pkg::entry_t rd_data_q;
  logic            valid_q [Depth];
  logic [IdxW-1:0] wr_idx, rd_idx, lk_idx;
  logic            bypass;

  assign wr_idx = wr_i.slot[IdxW-1:0];
  assign rd_idx = rd_slot_i[IdxW-1:0];
  assign lk_idx = lk_slot_i[IdxW-1:0];
  assign bypass = wr_i.en && (wr_i.slot == rd_slot_i);

  // Valid bits clear at reset; an invalid entry reads as all zero downstream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Depth; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (wr_i.en) begin
      valid_q[wr_idx] <= wr_i.valid;
    end
  end

  // Entry memory: one write port, one registered read port. A read that
  // meets a write to the same slot takes the new data.
  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem_q[wr_idx] <= wr_i.data;
    end
    if (rd_en_i) begin
      if (bypass) begin
        rd_data_q <= wr_i.data;
      end else begin
        rd_data_q <= mem_q[rd_idx];
      end
    end
  end

  assign rd_data_o  = rd_data_q;
  assign lk_valid_o = valid_q[lk_idx];

endmodule

/* hdl/vht_update.sv */
// ----------------------------------------------------------------------------
// Entry update logic
// Applies one item to its entry and forms the draw decision.
// ----------------------------------------------------------------------------
module vht_update #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned RUN_MAX = 255
) (
  input  logic              fire_i,
  input  vht_pkg::in_item_t item_i,
  input  vht_pkg::entry_t   rd_data_i,
  input  logic              entry_valid_i,
  input  vht_pkg::cfg_t     cfg_i,
  output vht_pkg::tbl_wr_t  wr_o,
  output logic              draw_o
);

  localparam logic [7:0] RunMax = 8'(RUN_MAX);

  logic            in_range;
  vht_pkg::entry_t base;
  vht_pkg::entry_t upd;

  assign in_range = (32'(item_i.slot) < 32'(ENTRIES));
  // An absent entry starts shown with both streaks at zero.
  assign base     = entry_valid_i ? rd_data_i : '0;

  // Streak and hidden flag update for an observe verdict.
  always_comb begin
    upd = base;
    if (item_i.seen_visible) begin
      upd.hidden_run = 8'd0;
      if (base.visible_run < RunMax) begin
        upd.visible_run = base.visible_run + 8'd1;
      end
      if (base.hidden && (upd.visible_run >= cfg_i.show_threshold)) begin
        upd.hidden = 1'b0;
      end
    end else begin
      upd.visible_run = 8'd0;
      if (base.hidden_run < RunMax) begin
        upd.hidden_run = base.hidden_run + 8'd1;
      end
      if (!base.hidden && (upd.hidden_run >= cfg_i.hide_threshold)) begin
        upd.hidden = 1'b1;
      end
    end
  end

  // Per-operation write request and result.
  always_comb begin
    wr_o       = '0;
    wr_o.slot  = item_i.slot;
    draw_o     = 1'b0;
    case (vht_pkg::op_e'(item_i.operation))
      vht_pkg::OP_OBSERVE: begin
        draw_o = 1'b1;
        if (in_range) begin
          wr_o.en    = fire_i;
          wr_o.valid = 1'b1;
          wr_o.data  = upd;
          draw_o     = !upd.hidden;
        end
      end
      vht_pkg::OP_UNTESTED: begin
        draw_o = 1'b1;
        if (in_range && entry_valid_i) begin
          wr_o.en              = fire_i;
          wr_o.valid           = 1'b1;
          wr_o.data            = rd_data_i;
          wr_o.data.hidden_run = 8'd0;
        end
      end
      vht_pkg::OP_EVICT: begin
        draw_o = 1'b0;
        if (in_range) begin
          wr_o.en    = fire_i;
          wr_o.valid = 1'b0;
        end
      end
      default: begin
        draw_o = 1'b0;
      end
    endcase
  end

endmodule

/* hdl/visibility_hysteresis_table.sv */
// The block accepts one item per clock cycle while the output is not stalled
// and returns exactly one result item for each, in order. An accepted item
// waits in the update stage register, and its result is then held in the
// result register until the output takes it. The entry memory is read once
// at acceptance through its registered read port; when the update stage
// advances, it updates the entry, writes it back and registers the result.
// A read that coincides with a write to the same slot takes the written
// data, so items that hit one slot back to back see each other's updates.
// Valid bits sit in flops and clear at reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
// Visibility hysteresis table
// Per-slot visibility state with streak counters and show/hide thresholds.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module visibility_hysteresis_table #(
  parameter int unsigned ENTRIES = 256,
  parameter int unsigned RUN_MAX = 255
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  vht_pkg::in_item_t  in_item_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output vht_pkg::out_item_t out_item_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  vht_pkg::cfg_t      cfg;
  vht_pkg::tbl_wr_t   wr;
  vht_pkg::entry_t    rd_data;
  logic               lk_valid;
  logic               draw;
  logic               in_accept;
  logic               s1_adv;

  logic               s1_valid_q, s1_valid_d;
  vht_pkg::in_item_t  s1_item_q;
  logic               out_valid_q, out_valid_d;
  vht_pkg::out_item_t out_item_q;

  vht_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  vht_table #(
    .ENTRIES (ENTRIES)
  ) u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_slot_i  (in_item_i.slot),
    .rd_data_o  (rd_data),
    .lk_slot_i  (s1_item_q.slot),
    .lk_valid_o (lk_valid),
    .wr_i       (wr)
  );

  vht_update #(
    .ENTRIES (ENTRIES),
    .RUN_MAX (RUN_MAX)
  ) u_update (
    .fire_i        (s1_adv),
    .item_i        (s1_item_q),
    .rd_data_i     (rd_data),
    .entry_valid_i (lk_valid),
    .cfg_i         (cfg),
    .wr_o          (wr),
    .draw_o        (draw)
  );

  // Handshake: the update stage moves on whenever the result register is
  // free or being emptied, and a new item enters behind it.
  assign s1_adv     = s1_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !s1_valid_q || s1_adv;
  assign in_accept  = in_valid_i && in_ready_o;

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_accept) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Item and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_item_q <= in_item_i;
    end
    if (s1_adv) begin
      out_item_q.draw_object <= draw;
      out_item_q.slot_echo   <= s1_item_q.slot;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // The table is written only when the update stage hands its result on.
  `ASSERT_IMPLIES(a_write_on_advance, clk_i, rst_ni, wr.en, s1_adv)
  // A stalled update stage keeps its item.
  `ASSERT_NEXT(a_s1_holds, clk_i, rst_ni, s1_valid_q && !s1_adv,
               s1_valid_q && $stable(s1_item_q))
  // An evict item always yields a no-draw result.
  `ASSERT_NEXT(a_evict_no_draw, clk_i, rst_ni,
               s1_adv && (s1_item_q.operation == vht_pkg::OP_EVICT),
               out_valid_o && !out_item_o.draw_object)
  // An untested item always yields a draw result.
  `ASSERT_NEXT(a_untested_draw, clk_i, rst_ni,
               s1_adv && (s1_item_q.operation == vht_pkg::OP_UNTESTED),
               out_valid_o && out_item_o.draw_object)

endmodule
